// ===== src/lbcs_pkg.sv =====
// Shared types, codes and timing constants of the LED blink-code sequencer.
package lbcs_pkg;

	localparam int CODE_DIGITS = 10;
	localparam int DIGITS_W    = 4 * CODE_DIGITS;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = DIGITS_W;
	localparam int LEN_W       = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DIGIT_VALUES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_DIGIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEGATIVE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LEVEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_LEVEL    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP      = 3'd6;

	localparam logic [LEN_W-1:0] T_VERY_SHORT     = 16'd60;
	localparam logic [LEN_W-1:0] T_SHORT          = 16'd300;
	localparam logic [LEN_W-1:0] T_SIGN           = 16'd2400;
	localparam logic [LEN_W-1:0] T_BETWEEN_BLINKS = 16'd300;
	localparam logic [LEN_W-1:0] T_BETWEEN_DIGITS = 16'd1200;
	localparam logic [LEN_W-1:0] T_BETWEEN_CODES  = 16'd3000;

	localparam logic [3:0] PH_CODE_IDLE      = 4'd0;
	localparam logic [3:0] PH_CODE_START     = 4'd1;
	localparam logic [3:0] PH_CODE_SIGN_ON   = 4'd2;
	localparam logic [3:0] PH_CODE_SIGN_OFF  = 4'd3;
	localparam logic [3:0] PH_CODE_READ      = 4'd4;
	localparam logic [3:0] PH_CODE_BLINK_ON  = 4'd5;
	localparam logic [3:0] PH_CODE_BLINK_OFF = 4'd6;
	localparam logic [3:0] PH_CODE_END       = 4'd7;
	localparam logic [3:0] PH_CODE_FINAL     = 4'd8;
	localparam logic [3:0] PH_CODE_REPEAT    = 4'd9;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	typedef enum logic [9:0] {
		PH_IDLE      = 10'b0000000001,
		PH_START     = 10'b0000000010,
		PH_SIGN_ON   = 10'b0000000100,
		PH_SIGN_OFF  = 10'b0000001000,
		PH_READ      = 10'b0000010000,
		PH_BLINK_ON  = 10'b0000100000,
		PH_BLINK_OFF = 10'b0001000000,
		PH_END       = 10'b0010000000,
		PH_FINAL     = 10'b0100000000,
		PH_REPEAT    = 10'b1000000000
	} phase_t;

	typedef struct packed {
		logic [DIGITS_W-1:0] digit_values;
		logic [3:0]          first_digit;
		logic                negative;
		logic [7:0]          repeat_count;
		logic [7:0]          bright_level;
		logic [7:0]          dim_level;
		logic [7:0]          pwm_top;
	} cfg_t;

	function automatic logic [3:0] phase_code(phase_t p);
		logic [3:0] c;
		case (p)
			PH_IDLE:      c = PH_CODE_IDLE;
			PH_START:     c = PH_CODE_START;
			PH_SIGN_ON:   c = PH_CODE_SIGN_ON;
			PH_SIGN_OFF:  c = PH_CODE_SIGN_OFF;
			PH_READ:      c = PH_CODE_READ;
			PH_BLINK_ON:  c = PH_CODE_BLINK_ON;
			PH_BLINK_OFF: c = PH_CODE_BLINK_OFF;
			PH_END:       c = PH_CODE_END;
			PH_FINAL:     c = PH_CODE_FINAL;
			PH_REPEAT:    c = PH_CODE_REPEAT;
			default:      c = PH_CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

// ===== src/lbcs_engine.sv =====
// Blink-code sequencer state: phase machine, PWM counter, digit and repeat counts.
module lbcs_engine #(
	parameter int NUM_DIGITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  operation,
	input  logic [31:0]           now_ms,
	input  lbcs_pkg::cfg_t        cfg,
	output logic                  led_nxt,
	output logic                  busy_nxt,
	output logic [3:0]            phase_nxt_code
);
	import lbcs_pkg::*;

	localparam int DIDX_W = ($clog2(NUM_DIGITS + 1) > 4) ? $clog2(NUM_DIGITS + 1) : 4;
	localparam int IDX_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

	phase_t             phase_q, phase_n;
	logic [31:0]        start_q, start_n;
	logic [LEN_W-1:0]   len_q, len_n;
	logic [7:0]         pwm_q, pwm_n;
	logic [DIDX_W-1:0]  didx_q, didx_n;
	logic [7:0]         reps_q, reps_n;
	logic               led_q, led_n;
	logic [4:0]         blinks_q [NUM_DIGITS];
	logic [4:0]         load_val [NUM_DIGITS];

	logic               load_code;
	logic               dec_blink;
	logic               in_range;
	logic [4:0]         cur_blinks;
	logic [4:0]         dec_val;
	logic               at_bright;
	logic               at_dim;
	logic               elapsed;
	logic [31:0]        delta;

	for (genvar d = 0; d < NUM_DIGITS; d++) begin : g_load
		if (d < CODE_DIGITS) begin : g_nib
			assign load_val[d] = {1'b0, cfg.digit_values[4*d +: 4]};
		end else begin : g_zero
			assign load_val[d] = '0;
		end
	end

	assign in_range   = didx_q < DIDX_W'(NUM_DIGITS);
	assign cur_blinks = in_range ? blinks_q[didx_q[IDX_W-1:0]] : '0;
	assign dec_val    = (cur_blinks != '0) ? cur_blinks - 5'd1 : cur_blinks;
	assign at_bright  = pwm_q == cfg.bright_level;
	assign at_dim     = pwm_q == cfg.dim_level;
	assign delta      = now_ms - start_q;
	// A zero start mark in the start phase is replaced by now, so the phase cannot end yet.
	assign elapsed    = at_bright && (delta > {16'd0, len_q}) &&
		!(phase_q == PH_START && start_q == '0);

	always_comb begin
		phase_n   = phase_q;
		start_n   = start_q;
		len_n     = len_q;
		pwm_n     = pwm_q;
		didx_n    = didx_q;
		reps_n    = reps_q;
		led_n     = led_q;
		load_code = 1'b0;
		dec_blink = 1'b0;
		if (operation == OP_START) begin
			load_code = 1'b1;
			didx_n    = DIDX_W'(cfg.first_digit);
			phase_n   = PH_START;
			len_n     = T_BETWEEN_DIGITS;
			reps_n    = cfg.repeat_count;
			start_n   = '0;
		end else begin
			if (pwm_q == 8'd0 && phase_q == PH_IDLE)
				led_n = 1'b0;
			if (phase_q != PH_IDLE && pwm_q == 8'd0 && len_q != T_VERY_SHORT &&
				phase_q != PH_REPEAT && phase_q != PH_FINAL)
				led_n = 1'b1;
			case (phase_q)
				PH_START: begin
					if (start_q == '0)
						start_n = now_ms;
					if (at_dim)
						led_n = 1'b0;
					if (elapsed) begin
						if (cfg.negative) begin
							phase_n = PH_SIGN_ON;
							len_n   = T_SIGN;
						end else begin
							phase_n = PH_READ;
						end
						start_n = now_ms;
					end
				end
				PH_SIGN_ON: begin
					if (at_bright)
						led_n = 1'b0;
					if (elapsed) begin
						phase_n = PH_SIGN_OFF;
						len_n   = T_SIGN;
						start_n = now_ms;
					end
				end
				PH_SIGN_OFF: begin
					if (at_dim)
						led_n = 1'b0;
					if (elapsed) begin
						phase_n = PH_READ;
						len_n   = T_BETWEEN_DIGITS;
						start_n = now_ms;
					end
				end
				PH_READ: begin
					if (!in_range) begin
						if (reps_q != 8'd0)
							reps_n = reps_q - 8'd1;
						phase_n = PH_END;
						len_n   = T_BETWEEN_DIGITS;
					end else begin
						len_n   = (cur_blinks == '0) ? T_VERY_SHORT : T_SHORT;
						phase_n = PH_BLINK_ON;
					end
					start_n = now_ms;
				end
				PH_BLINK_ON: begin
					if (at_bright)
						led_n = 1'b0;
					if (elapsed && in_range) begin
						phase_n   = PH_BLINK_OFF;
						start_n   = now_ms;
						dec_blink = 1'b1;
						len_n     = (dec_val != '0) ? T_BETWEEN_BLINKS : T_BETWEEN_DIGITS;
					end
				end
				PH_BLINK_OFF: begin
					if (at_dim)
						led_n = 1'b0;
					if (elapsed) begin
						if (in_range && cur_blinks != '0) begin
							phase_n = PH_BLINK_ON;
							len_n   = T_SHORT;
						end else begin
							if (in_range)
								didx_n = didx_q + DIDX_W'(1);
							phase_n = PH_READ;
						end
						start_n = now_ms;
					end
				end
				PH_END: begin
					if (at_dim)
						led_n = 1'b0;
					if (elapsed) begin
						if (reps_q == 8'd0) begin
							phase_n = PH_FINAL;
							len_n   = T_BETWEEN_DIGITS;
						end else begin
							phase_n = PH_REPEAT;
							len_n   = T_BETWEEN_CODES;
						end
						start_n = now_ms;
					end
				end
				PH_FINAL: begin
					if (elapsed) begin
						phase_n = PH_IDLE;
						start_n = now_ms;
					end
				end
				PH_REPEAT: begin
					if (elapsed) begin
						load_code = 1'b1;
						didx_n    = DIDX_W'(cfg.first_digit);
						phase_n   = PH_START;
						len_n     = T_BETWEEN_DIGITS;
						start_n   = now_ms;
					end
				end
				default: begin
				end
			endcase
			pwm_n = (pwm_q > cfg.pwm_top) ? 8'd0 : pwm_q + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			start_q <= '0;
			len_q   <= '0;
			pwm_q   <= '0;
			didx_q  <= '0;
			reps_q  <= '0;
			led_q   <= 1'b0;
			for (int d = 0; d < NUM_DIGITS; d++)
				blinks_q[d] <= '0;
		end else if (item_valid) begin
			phase_q <= phase_n;
			start_q <= start_n;
			len_q   <= len_n;
			pwm_q   <= pwm_n;
			didx_q  <= didx_n;
			reps_q  <= reps_n;
			led_q   <= led_n;
			if (load_code) begin
				for (int d = 0; d < NUM_DIGITS; d++)
					blinks_q[d] <= load_val[d];
			end else if (dec_blink) begin
				blinks_q[didx_q[IDX_W-1:0]] <= dec_val;
			end
		end
	end

	assign led_nxt        = led_n;
	assign busy_nxt       = phase_n != PH_IDLE;
	assign phase_nxt_code = phase_code(phase_n);

	a_start_enters_start: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && operation == OP_START |=> phase_q == PH_START)
		else $error("start transaction did not enter start phase");

	a_blink_digit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BLINK_ON || phase_q == PH_BLINK_OFF) |-> in_range)
		else $error("blinking with digit index past last digit");

	a_hold_without_item: assert property (@(posedge clk) disable iff (!arst_n)
		!item_valid |=> $stable(phase_q) && $stable(pwm_q) && $stable(led_q))
		else $error("state moved without a transaction");

endmodule

// ===== src/led_blink_code_sequencer.sv =====
// LED blink-code sequencer top level: stream ports, configuration registers, output register.
// Takes one transaction per clock cycle unless the output side stalls: each tick or start
// command is latched in an input register, the sequencer state is updated from it when the
// output register can advance, and the resulting LED level, busy flag and phase land in
// that output register; one result comes out for every transaction. The path that sets
// the clock is the 32-bit elapsed-time subtract and compare feeding the phase machine.
// Configuration writes take effect at once and are meant to happen while no code is shown.
module led_blink_code_sequencer #(
	parameter int NUM_DIGITS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [31:0]                      s_tdata,   // now_ms[31:0]
	input  logic                             s_tuser,   // operation
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,   // led_on, busy_res, phase_now[3:0], 0
	input  logic                             cfg_we,
	input  logic [lbcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lbcs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import lbcs_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic        op_s1;
	logic [31:0] now_s1;
	logic        out_valid_q;
	logic        led_q;
	logic        busy_q;
	logic [3:0]  phase_num_q;
	logic        advance;
	logic        led_nxt;
	logic        busy_nxt;
	logic [3:0]  phase_nxt_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.digit_values <= '0;
			cfg_q.first_digit  <= '0;
			cfg_q.negative     <= 1'b0;
			cfg_q.repeat_count <= 8'd1;
			cfg_q.bright_level <= 8'd200;
			cfg_q.dim_level    <= 8'd10;
			cfg_q.pwm_top      <= 8'd253;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIGIT_VALUES: cfg_q.digit_values <= cfg_wdata[DIGITS_W-1:0];
				REG_FIRST_DIGIT:  cfg_q.first_digit  <= cfg_wdata[3:0];
				REG_NEGATIVE:     cfg_q.negative     <= cfg_wdata[0];
				REG_REPEAT_COUNT: cfg_q.repeat_count <= cfg_wdata[7:0];
				REG_BRIGHT_LEVEL: cfg_q.bright_level <= cfg_wdata[7:0];
				REG_DIM_LEVEL:    cfg_q.dim_level    <= cfg_wdata[7:0];
				REG_PWM_TOP:      cfg_q.pwm_top      <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= s_tuser;
			now_s1 <= s_tdata;
		end
		if (valid_s1 && advance) begin
			led_q       <= led_nxt;
			busy_q      <= busy_nxt;
			phase_num_q <= phase_nxt_code;
		end
	end

	lbcs_engine #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (valid_s1 && advance),
		.operation      (op_s1),
		.now_ms         (now_s1),
		.cfg            (cfg_q),
		.led_nxt        (led_nxt),
		.busy_nxt       (busy_nxt),
		.phase_nxt_code (phase_nxt_code)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, phase_num_q, busy_q, led_q};

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |-> !s_tready)
		else $error("input taken while both stages are stalled");

	a_item_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> m_tvalid)
		else $error("processed transaction produced no result");

	a_busy_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1] == (m_tdata[5:2] != PH_CODE_IDLE)))
		else $error("busy flag disagrees with phase");

endmodule
